### rtl/datc_pkg.sv
// ----------------------------------------------------------------------------
// datc_pkg
// shared sizes, state encoding and control structs of the triangle counter
// ----------------------------------------------------------------------------
package datc_pkg;

  localparam int MAX_NODES     = 64;
  localparam int ADDR_W        = $clog2(MAX_NODES);
  localparam int CNT_W         = $clog2(MAX_NODES + 1);
  localparam int VERT_W        = 6;
  localparam int NODE_CFG_W    = 7;
  localparam int COUNT_W       = 16;
  localparam int NUM_GRP       = (MAX_NODES + 7) / 8;
  localparam int PAD_W         = NUM_GRP * 8;
  localparam int GRP_CNT_W     = 4;
  localparam int MAX_TRIANGLES = MAX_NODES * (MAX_NODES - 1) * (MAX_NODES - 2) / 6;

  localparam logic [NODE_CFG_W-1:0] NODE_RESET = NODE_CFG_W'(64);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              wr_edge;
    logic              start;
    logic              rd_en;
    logic              load_row;
    logic              pair;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] col;
    logic [CNT_W-1:0]  nc;
    logic              publish;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

endpackage

### rtl/dense_adjacency_triangle_count_top.sv
// ----------------------------------------------------------------------------
// dense_adjacency_triangle_count_top
// triangle counter over a dense adjacency bit matrix of up to 64 vertices
// ----------------------------------------------------------------------------
// Edge words load one per clock while idle into an upper-triangle bit matrix
// held in a 64 x 64-bit memory. The word flagged as last edge is stored and
// then starts the count: the sequencer walks every row i and every column j
// above it through the single read port of that memory, one row or one pair
// per cycle, while input is held off. The count is then moved to the output
// register, the running total is cleared and the matrix is cleared at once
// through per-row valid flags; edge loading of the next graph may start while
// the result word still waits to be taken.
module dense_adjacency_triangle_count_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [datc_pkg::VERT_W-1:0]       in_row_vertex,
  input  logic [datc_pkg::VERT_W-1:0]       in_col_vertex,
  input  logic                              in_last_edge,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [datc_pkg::COUNT_W-1:0]      out_triangle_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [datc_pkg::NODE_CFG_W-1:0]   cfg_node_count
);

  datc_pkg::cmd_t cmd;
  datc_pkg::sts_t sts;

  datc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_edge   (in_last_edge),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cfg_valid      (cfg_valid),
    .cfg_node_count (cfg_node_count),
    .cfg_ready      (cfg_ready),
    .cmd            (cmd),
    .sts            (sts)
  );

  datc_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_row_vertex      (in_row_vertex),
    .in_col_vertex      (in_col_vertex),
    .out_triangle_count (out_triangle_count)
  );

endmodule

### rtl/datc_dpath.sv
// ----------------------------------------------------------------------------
// datc_dpath
// upper-triangle adjacency memory, row pair and/popcount pipeline, total
// ----------------------------------------------------------------------------
module datc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  datc_pkg::cmd_t                     cmd,
  output datc_pkg::sts_t                     sts,
  input  logic [datc_pkg::VERT_W-1:0]        in_row_vertex,
  input  logic [datc_pkg::VERT_W-1:0]        in_col_vertex,
  output logic [datc_pkg::COUNT_W-1:0]       out_triangle_count
);

  logic [datc_pkg::MAX_NODES-1:0] mem [datc_pkg::MAX_NODES];
  logic [datc_pkg::MAX_NODES-1:0] row_vld_r;

  logic [datc_pkg::VERT_W-1:0]    lo_v;
  logic [datc_pkg::VERT_W-1:0]    hi_v;
  logic                           edge_ok;
  logic [datc_pkg::ADDR_W-1:0]    wa;
  logic [datc_pkg::ADDR_W-1:0]    wb;
  logic [datc_pkg::MAX_NODES-1:0] onehot;

  logic [datc_pkg::MAX_NODES-1:0] rd_q_r;
  logic                           rd_vld_r;
  logic [datc_pkg::MAX_NODES-1:0] rd_row;

  logic                           ld_row_q_r;
  logic                           pair_q_r;
  logic [datc_pkg::ADDR_W-1:0]    col_q_r;
  logic [datc_pkg::MAX_NODES-1:0] row_i_r;
  logic [datc_pkg::MAX_NODES-1:0] range_r;
  logic [datc_pkg::MAX_NODES-1:0] range_nxt;

  logic [datc_pkg::MAX_NODES-1:0] and_r;
  logic                           and_v_r;
  logic [datc_pkg::PAD_W-1:0]     and_pad;
  logic [datc_pkg::GRP_CNT_W-1:0] grp_cnt_nxt [datc_pkg::NUM_GRP];
  logic [datc_pkg::GRP_CNT_W-1:0] grp_cnt_r   [datc_pkg::NUM_GRP];
  logic                           grp_v_r;
  logic [datc_pkg::CNT_W-1:0]     cnt_nxt;
  logic [datc_pkg::CNT_W-1:0]     cnt_r;
  logic                           cnt_v_r;

  logic [datc_pkg::COUNT_W-1:0]   total_r;
  logic [datc_pkg::COUNT_W-1:0]   out_count_r;

  // edge goes to row min, column max; self loops are dropped
  always_comb begin
    if (in_row_vertex < in_col_vertex) begin
      lo_v = in_row_vertex;
      hi_v = in_col_vertex;
    end else begin
      lo_v = in_col_vertex;
      hi_v = in_row_vertex;
    end
    edge_ok = cmd.wr_edge && (in_row_vertex != in_col_vertex)
              && ({1'b0, in_row_vertex} < (datc_pkg::VERT_W+1)'(datc_pkg::MAX_NODES))
              && ({1'b0, in_col_vertex} < (datc_pkg::VERT_W+1)'(datc_pkg::MAX_NODES));
    wa     = lo_v[datc_pkg::ADDR_W-1:0];
    wb     = hi_v[datc_pkg::ADDR_W-1:0];
    onehot = {{(datc_pkg::MAX_NODES-1){1'b0}}, 1'b1} << wb;
  end

  always_ff @(posedge clk) begin
    if (edge_ok) begin
      if (row_vld_r[wa]) begin
        mem[wa][wb] <= 1'b1;
      end else begin
        mem[wa] <= onehot;
      end
    end
    if (cmd.rd_en) begin
      rd_q_r   <= mem[cmd.rd_addr];
      rd_vld_r <= row_vld_r[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.publish) begin
      row_vld_r <= '0;
    end else if (edge_ok) begin
      row_vld_r[wa] <= 1'b1;
    end
  end

  assign rd_row = rd_vld_r ? rd_q_r : '0;

  // vertices below the node count
  always_comb begin
    for (int k = 0; k < datc_pkg::MAX_NODES; k++) begin
      range_nxt[k] = (datc_pkg::CNT_W'(k) < cmd.nc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      range_r <= range_nxt;
    end
    if (cmd.pair) begin
      col_q_r <= cmd.col;
    end
    if (ld_row_q_r) begin
      row_i_r <= rd_row;
    end
    if (pair_q_r) begin
      and_r <= row_i_r & rd_row & range_r & {datc_pkg::MAX_NODES{row_i_r[col_q_r]}};
    end
    if (and_v_r) begin
      grp_cnt_r <= grp_cnt_nxt;
    end
    if (grp_v_r) begin
      cnt_r <= cnt_nxt;
    end
    if (cmd.publish) begin
      out_count_r <= total_r;
    end
  end

  assign and_pad = datc_pkg::PAD_W'(and_r);

  always_comb begin
    for (int g = 0; g < datc_pkg::NUM_GRP; g++) begin
      grp_cnt_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_cnt_nxt[g] = grp_cnt_nxt[g]
                         + datc_pkg::GRP_CNT_W'(and_pad[g*8+b]);
      end
    end
  end

  always_comb begin
    cnt_nxt = '0;
    for (int g = 0; g < datc_pkg::NUM_GRP; g++) begin
      cnt_nxt = cnt_nxt + datc_pkg::CNT_W'(grp_cnt_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_row_q_r <= 1'b0;
      pair_q_r   <= 1'b0;
      and_v_r    <= 1'b0;
      grp_v_r    <= 1'b0;
      cnt_v_r    <= 1'b0;
      total_r    <= '0;
    end else begin
      ld_row_q_r <= cmd.load_row;
      pair_q_r   <= cmd.pair;
      and_v_r    <= pair_q_r;
      grp_v_r    <= and_v_r;
      cnt_v_r    <= grp_v_r;
      if (cmd.publish) begin
        total_r <= '0;
      end else if (cnt_v_r) begin
        total_r <= total_r + datc_pkg::COUNT_W'(cnt_r);
      end
    end
  end

  assign sts.busy          = pair_q_r | and_v_r | grp_v_r | cnt_v_r;
  assign out_triangle_count = out_count_r;

endmodule

### rtl/datc_ctrl.sv
// ----------------------------------------------------------------------------
// datc_ctrl
// handshakes, node count register and the row/column walk sequencer
// ----------------------------------------------------------------------------
module datc_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_last_edge,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              cfg_valid,
  input  logic [datc_pkg::NODE_CFG_W-1:0]   cfg_node_count,
  output logic                              cfg_ready,
  output datc_pkg::cmd_t                    cmd,
  input  datc_pkg::sts_t                    sts
);

  datc_pkg::state_t                  state_r, state_nxt;
  logic [datc_pkg::NODE_CFG_W-1:0]   node_count_r;
  logic [datc_pkg::CNT_W-1:0]        nc_r, nc_nxt;
  logic [datc_pkg::CNT_W-1:0]        i_r, i_nxt;
  logic [datc_pkg::CNT_W-1:0]        j_r, j_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [datc_pkg::NODE_CFG_W-1:0]   nc_sat;

  assign nc_sat = (node_count_r > datc_pkg::NODE_CFG_W'(datc_pkg::MAX_NODES))
                  ? datc_pkg::NODE_CFG_W'(datc_pkg::MAX_NODES) : node_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= datc_pkg::ST_IDLE;
      node_count_r <= datc_pkg::NODE_RESET;
      nc_r         <= '0;
      i_r          <= '0;
      j_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nc_r        <= nc_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    nc_nxt        = nc_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.nc        = datc_pkg::CNT_W'(nc_sat);
    cmd.rd_addr   = i_r[datc_pkg::ADDR_W-1:0];
    cmd.col       = j_r[datc_pkg::ADDR_W-1:0];
    unique case (state_r)
      datc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.wr_edge = in_valid;
        if (in_valid && in_last_edge) begin
          cmd.start = 1'b1;
          nc_nxt    = datc_pkg::CNT_W'(nc_sat);
          i_nxt     = '0;
          state_nxt = datc_pkg::ST_ROW;
        end
      end
      datc_pkg::ST_ROW: begin
        if (i_r + datc_pkg::CNT_W'(1) >= nc_r) begin
          state_nxt = datc_pkg::ST_DRAIN;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.load_row = 1'b1;
          j_nxt        = i_r + datc_pkg::CNT_W'(1);
          state_nxt    = datc_pkg::ST_COL;
        end
      end
      datc_pkg::ST_COL: begin
        cmd.rd_en   = 1'b1;
        cmd.pair    = 1'b1;
        cmd.rd_addr = j_r[datc_pkg::ADDR_W-1:0];
        if (j_r + datc_pkg::CNT_W'(1) >= nc_r) begin
          i_nxt     = i_r + datc_pkg::CNT_W'(1);
          state_nxt = datc_pkg::ST_ROW;
        end else begin
          j_nxt = j_r + datc_pkg::CNT_W'(1);
        end
      end
      datc_pkg::ST_DRAIN: begin
        // result register must be free before the total moves into it
        if (!sts.busy && (!out_valid_r || out_ready)) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = datc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = datc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

endmodule

### rtl/datc_checker.sv
// ----------------------------------------------------------------------------
// datc_checker
// port-level checks of the triangle counter, bound to the top level
// ----------------------------------------------------------------------------
module datc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last_edge,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [datc_pkg::COUNT_W-1:0]      out_triangle_count
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_triangle_count))
    else $error("result word changed while stalled");

  // count never exceeds the number of vertex triples
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_triangle_count <= datc_pkg::COUNT_W'(datc_pkg::MAX_TRIANGLES))
    else $error("triangle count out of range");

  // last edge starts the walk, input held off
  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_edge |=> !in_ready)
    else $error("input taken right after last edge");

  // ordinary edges load back to back
  a_edge_rate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_edge |=> in_ready)
    else $error("input stalled after ordinary edge");

  // new result appears only at the end of a walk
  a_out_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised outside of counting");

endmodule

bind dense_adjacency_triangle_count_top datc_checker u_datc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_last_edge       (in_last_edge),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_triangle_count (out_triangle_count)
);

### tb/sv/dense_adjacency_triangle_count_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dense_adjacency_triangle_count_top_tb
// self-checking bench for the dense adjacency triangle counter
// ----------------------------------------------------------------------------
// Edge words are driven over a valid/ready input channel. A bit-matrix
// predictor in the bench counts the triangles of each graph closed by a last
// edge, and the count words taken from the output channel are checked in
// order against it. A directed table covers an empty graph, boundary vertices,
// node counts of zero, one and above the matrix size, vertices past the node
// count, repeated edges, self loops and a node count change while a graph is
// loading. Random graphs follow, written under a range of node counts, with
// bursty input, a stalling receiver and one long output hold-off.
// ----------------------------------------------------------------------------
module dense_adjacency_triangle_count_top_tb;

  localparam int RANDOM_EDGES  = 1350;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES   = 2200;
  localparam int CYCLE_LIMIT   = 20000000;
  localparam int LONG_HOLD     = 6000;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic {
    ROW_EDGE,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [datc_pkg::NODE_CFG_W-1:0] nodes;
    logic [datc_pkg::VERT_W-1:0]     row_v;
    logic [datc_pkg::VERT_W-1:0]     col_v;
    logic                            last;
    logic                            typed;
    logic [datc_pkg::COUNT_W-1:0]    count;
  } dir_row_t;

  localparam int DIR_LEN = 29;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [datc_pkg::VERT_W-1:0]     in_row_vertex;
  logic [datc_pkg::VERT_W-1:0]     in_col_vertex;
  logic                            in_last_edge;
  logic                            out_valid;
  logic                            out_ready;
  logic [datc_pkg::COUNT_W-1:0]    out_triangle_count;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [datc_pkg::NODE_CFG_W-1:0] cfg_node_count;

  logic [datc_pkg::MAX_NODES-1:0]  graph_rows [datc_pkg::MAX_NODES];
  logic [datc_pkg::NODE_CFG_W-1:0] graph_nodes;
  logic [datc_pkg::COUNT_W-1:0]    pending_counts [$];
  int                              mismatches;
  int                              counts_seen;
  int                              cycle_count;
  bit                              long_hold_done;
  bit                              hold_req;
  int                              hold_left;
  int                              ready_mode;

  dir_row_t dir_tbl [DIR_LEN] = '{
    '{ROW_EDGE, 7'd0,   6'd0,  6'd0,  1'b1, 1'b1, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd0,  6'd1,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd1,  6'd2,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd2,  6'd0,  1'b1, 1'b1, 16'd1},
    '{ROW_EDGE, 7'd0,   6'd63, 6'd62, 1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd62, 6'd61, 1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd61, 6'd63, 1'b1, 1'b1, 16'd1},
    '{ROW_CFG,  7'd3,   6'd0,  6'd0,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd0,  6'd1,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd1,  6'd2,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd0,  6'd3,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd1,  6'd0,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd0,  6'd2,  1'b1, 1'b0, 16'd0},
    '{ROW_CFG,  7'd0,   6'd0,  6'd0,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd0,  6'd1,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd1,  6'd2,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd0,  6'd2,  1'b1, 1'b1, 16'd0},
    '{ROW_CFG,  7'd127, 6'd0,  6'd0,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd61, 6'd62, 1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd62, 6'd63, 1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd63, 6'd61, 1'b1, 1'b1, 16'd1},
    '{ROW_CFG,  7'd1,   6'd0,  6'd0,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd0,  6'd0,  1'b1, 1'b1, 16'd0},
    '{ROW_CFG,  7'd64,  6'd0,  6'd0,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd10, 6'd11, 1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd11, 6'd12, 1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd10, 6'd12, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  7'd12,  6'd0,  6'd0,  1'b0, 1'b0, 16'd0},
    '{ROW_EDGE, 7'd0,   6'd0,  6'd0,  1'b1, 1'b0, 16'd0}
  };

  dense_adjacency_triangle_count_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_row_vertex      (in_row_vertex),
    .in_col_vertex      (in_col_vertex),
    .in_last_edge       (in_last_edge),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_triangle_count (out_triangle_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_node_count     (cfg_node_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_graph();
    for (int i = 0; i < datc_pkg::MAX_NODES; i++) graph_rows[i] = '0;
  endfunction

  function automatic logic [datc_pkg::COUNT_W-1:0] count_and_clear_triangles();
    int                             nodes_used;
    logic [datc_pkg::MAX_NODES-1:0] in_range;
    logic [datc_pkg::MAX_NODES-1:0] above_j;
    logic [datc_pkg::COUNT_W-1:0]   total;
    nodes_used = (graph_nodes > datc_pkg::MAX_NODES) ? datc_pkg::MAX_NODES
                                                     : int'(graph_nodes);
    in_range   = (nodes_used >= datc_pkg::MAX_NODES) ? '1
                                                     : ((64'd1 << nodes_used) - 64'd1);
    total      = '0;
    for (int i = 0; i < nodes_used; i++) begin
      for (int j = i + 1; j < nodes_used; j++) begin
        if (graph_rows[i][j]) begin
          above_j = ((j + 1 >= datc_pkg::MAX_NODES) ? '0 : ~((64'd1 << (j + 1)) - 64'd1))
                    & in_range;
          total   = total + datc_pkg::COUNT_W'($countones(graph_rows[i] & graph_rows[j]
                                                          & above_j));
        end
      end
    end
    clear_graph();
    return total;
  endfunction

  function automatic logic [datc_pkg::VERT_W-1:0] pick_vertex(int span, int base);
    if ($urandom_range(0, 9) == 0)
      return datc_pkg::VERT_W'($urandom_range(0, datc_pkg::MAX_NODES - 1));
    if (span > 12) return datc_pkg::VERT_W'(base + $urandom_range(0, 7));
    return datc_pkg::VERT_W'($urandom_range(0, span - 1));
  endfunction

  task automatic send_edge(input logic [datc_pkg::VERT_W-1:0] r,
                           input logic [datc_pkg::VERT_W-1:0] c,
                           input logic last, input logic typed,
                           input logic [datc_pkg::COUNT_W-1:0] typed_count);
    logic [datc_pkg::COUNT_W-1:0] predicted;
    in_valid      <= 1'b1;
    in_row_vertex <= r;
    in_col_vertex <= c;
    in_last_edge  <= last;
    do @(posedge clk); while (!in_ready);
    graph_rows[r][c] = 1'b1;
    graph_rows[c][r] = 1'b1;
    if (last) begin
      predicted = count_and_clear_triangles();
      pending_counts.push_back(typed ? typed_count : predicted);
    end
  endtask

  task automatic drain_counts();
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [datc_pkg::NODE_CFG_W-1:0] value);
    drain_counts();
    cfg_valid      <= 1'b1;
    cfg_node_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    graph_nodes  = value;
  endtask

  initial begin
    int                              sent;
    int                              graphs;
    int                              n_edges;
    int                              span;
    int                              base;
    int                              gap;
    int                              burst_left;
    int                              sel;
    bit                              no_idle;
    bit                              broken;
    bit                              pressure;
    logic [datc_pkg::NODE_CFG_W-1:0] nodes;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_row_vertex  = '0;
    in_col_vertex  = '0;
    in_last_edge   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_node_count = '0;
    hold_req       = 1'b0;
    graph_nodes    = datc_pkg::NODE_RESET;
    clear_graph();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_LEN; i++) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        write_node_count(dir_tbl[i].nodes);
      end else begin
        send_edge(dir_tbl[i].row_v, dir_tbl[i].col_v, dir_tbl[i].last,
                  dir_tbl[i].typed, dir_tbl[i].count);
      end
    end

    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_EDGES) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       nodes = 7'd0;
        1:       nodes = 7'd1;
        2:       nodes = 7'd2;
        3:       nodes = 7'd3;
        4:       nodes = 7'd64;
        5:       nodes = 7'd127;
        6:       nodes = datc_pkg::NODE_CFG_W'($urandom_range(65, 127));
        default: nodes = datc_pkg::NODE_CFG_W'($urandom_range(4, 16));
      endcase
      write_node_count(nodes);
      // several closed graphs under the long output hold-off
      pressure = !hold_req && (counts_seen >= 12);
      if (pressure) hold_req = 1'b1;
      no_idle = ($urandom_range(0, 3) == 0);
      graphs  = pressure ? 4 : $urandom_range(1, 4);
      for (int g = 0; g < graphs; g++) begin
        span    = (nodes < 2) ? datc_pkg::MAX_NODES
                  : ((nodes > datc_pkg::MAX_NODES) ? datc_pkg::MAX_NODES : int'(nodes));
        base    = (span > 12) ? $urandom_range(0, span - 8) : 0;
        n_edges = $urandom_range(1, 24);
        broken  = !pressure && ($urandom_range(0, 7) == 0);
        for (int e = 0; e < n_edges; e++) begin
          if (!no_idle) begin
            if (burst_left == 0) begin
              gap = $urandom_range(0, 8);
              if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
              end
              burst_left = $urandom_range(1, 16);
            end
            burst_left--;
          end
          send_edge(pick_vertex(span, base), pick_vertex(span, base),
                    (e == n_edges - 1) && !broken, 1'b0, '0);
          sent++;
        end
      end
    end

    drain_counts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    hold_left      = 0;
    ready_mode     = 0;
    forever begin
      @(posedge clk);
      if (cycle_count % 128 == 0) ready_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && hold_req) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        out_ready     <= 1'b0;
      end else begin
        case (ready_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    logic [datc_pkg::COUNT_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      counts_seen++;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected count word: actual %0d", out_triangle_count);
      end else begin
        want = pending_counts.pop_front();
        if (out_triangle_count !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("triangle_count mismatch: expected %0d actual %0d",
                     want, out_triangle_count);
        end
      end
    end
  end

  initial begin
    mismatches  = 0;
    counts_seen = 0;
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
